// ===== design/wos_pkg.sv =====
// Shared types, codes and constants for the window order statistics block.
package wos_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int OUT_BITS        = 17;

   // Operation codes
   localparam logic [2:0] OP_MIN    = 3'd0;
   localparam logic [2:0] OP_MEDIAN = 3'd1;
   localparam logic [2:0] OP_MAX    = 3'd2;
   localparam logic [2:0] OP_SPAN   = 3'd3;
   localparam logic [2:0] OP_MEAN   = 3'd4;

   // Window size register codes; the unused code selects nine samples
   localparam logic [1:0] WIN_3 = 2'd0;
   localparam logic [1:0] WIN_5 = 2'd1;
   localparam logic [1:0] WIN_9 = 2'd2;

   // Mean reciprocal constants
   localparam int DIV3_MUL   = 1431655766;
   localparam int DIV5_ROUND = 15;
   localparam int DIV9_ROUND = 62;

   typedef struct packed {
      logic       valid;
      logic [2:0] opcode;
      logic [1:0] win;
   } ctrl_type;

endpackage

// ===== design/wos_lane.sv =====
// One sorting lane: orders three samples and sums them, registered.
module wos_lane
   #(parameter int SAMPLE_BITS = wos_pkg::SAMPLE_BITS_DEF)
   (
   input  logic                          clock,
   input  logic signed [SAMPLE_BITS-1:0] smp_a,
   input  logic signed [SAMPLE_BITS-1:0] smp_b,
   input  logic signed [SAMPLE_BITS-1:0] smp_c,
   output logic signed [SAMPLE_BITS-1:0] lo,
   output logic signed [SAMPLE_BITS-1:0] mid,
   output logic signed [SAMPLE_BITS-1:0] hi,
   output logic signed [SAMPLE_BITS+1:0] sum
   );

   localparam int SUM_W = SAMPLE_BITS + 2;

   function automatic logic signed [SAMPLE_BITS-1:0] lo2(
      input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] hi2(
      input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b);
      return (a > b) ? a : b;
   endfunction

   logic signed [SAMPLE_BITS-1:0] ab_lo, ab_hi;
   logic signed [SAMPLE_BITS-1:0] lo_in, mid_in, hi_in;
   logic signed [SAMPLE_BITS-1:0] lo_ff, mid_ff, hi_ff;
   logic signed [SUM_W-1:0]       sum_in, sum_ff;

   always_comb begin
      ab_lo  = lo2(smp_a, smp_b);
      ab_hi  = hi2(smp_a, smp_b);
      lo_in  = lo2(ab_lo, smp_c);
      hi_in  = hi2(ab_hi, smp_c);
      mid_in = hi2(ab_lo, lo2(ab_hi, smp_c));
      sum_in = SUM_W'(smp_a) + SUM_W'(smp_b) + SUM_W'(smp_c);
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      sum_ff <= sum_in;
   end

   assign lo  = lo_ff;
   assign mid = mid_ff;
   assign hi  = hi_ff;
   assign sum = sum_ff;

endmodule

// ===== design/wos_merge.sv =====
// Merge stage: combines lane results into min, max, median and sum per window size.
module wos_merge
   #(parameter int SAMPLE_BITS = wos_pkg::SAMPLE_BITS_DEF)
   (
   input  logic                          clock,
   input  logic                          reset,
   input  wos_pkg::ctrl_type             ctrl_i,
   input  logic signed [SAMPLE_BITS-1:0] lane_lo  [3],
   input  logic signed [SAMPLE_BITS-1:0] lane_mid [3],
   input  logic signed [SAMPLE_BITS-1:0] lane_hi  [3],
   input  logic signed [SAMPLE_BITS+1:0] lane_sum [3],
   input  logic signed [SAMPLE_BITS-1:0] s2,
   input  logic signed [SAMPLE_BITS-1:0] s3,
   input  logic signed [SAMPLE_BITS-1:0] s4,
   input  logic signed [SAMPLE_BITS-1:0] m5_lo,
   input  logic signed [SAMPLE_BITS-1:0] m5_hi,
   output wos_pkg::ctrl_type             ctrl_o,
   output logic signed [SAMPLE_BITS-1:0] mn,
   output logic signed [SAMPLE_BITS-1:0] mx,
   output logic signed [SAMPLE_BITS-1:0] med,
   output logic signed [SAMPLE_BITS+3:0] sum
   );
   import wos_pkg::*;

   localparam int SUM_W = SAMPLE_BITS + 4;

   function automatic logic signed [SAMPLE_BITS-1:0] lo2(
      input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] hi2(
      input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] med3(
      input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b,
      input logic signed [SAMPLE_BITS-1:0] c);
      return hi2(lo2(a, b), lo2(hi2(a, b), c));
   endfunction

   logic signed [SAMPLE_BITS-1:0] lo9, hi9, med9, lo5, hi5;
   logic signed [SAMPLE_BITS-1:0] col_lo, col_mid, col_hi;
   logic signed [SAMPLE_BITS-1:0] mn_in, mx_in, med_in;
   logic signed [SAMPLE_BITS-1:0] mn_ff, mx_ff, med_ff;
   logic signed [SUM_W-1:0]       sum_in, sum_ff, sum3, sum5, sum9;
   ctrl_type                      ctrl_ff;

   always_comb begin
      lo9 = lo2(lo2(lane_lo[0], lane_lo[1]), lane_lo[2]);
      hi9 = hi2(hi2(lane_hi[0], lane_hi[1]), lane_hi[2]);
      lo5 = lo2(lane_lo[0], lo2(s3, s4));
      hi5 = hi2(lane_hi[0], hi2(s3, s4));

      // median of nine from sorted rows: max of lows, median of mids, min of highs
      col_lo  = hi2(hi2(lane_lo[0], lane_lo[1]), lane_lo[2]);
      col_mid = med3(lane_mid[0], lane_mid[1], lane_mid[2]);
      col_hi  = lo2(lo2(lane_hi[0], lane_hi[1]), lane_hi[2]);
      med9    = med3(col_lo, col_mid, col_hi);

      sum3 = SUM_W'(lane_sum[0]);
      sum5 = SUM_W'(lane_sum[0]) + SUM_W'(s3) + SUM_W'(s4);
      sum9 = SUM_W'(lane_sum[0]) + SUM_W'(lane_sum[1]) + SUM_W'(lane_sum[2]);

      unique case (ctrl_i.win)
         WIN_3: begin
            mn_in  = lane_lo[0];
            mx_in  = lane_hi[0];
            med_in = lane_mid[0];
            sum_in = sum3;
         end
         WIN_5: begin
            mn_in  = lo5;
            mx_in  = hi5;
            med_in = med3(m5_hi, s2, m5_lo);
            sum_in = sum5;
         end
         default: begin
            mn_in  = lo9;
            mx_in  = hi9;
            med_in = med9;
            sum_in = sum9;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      mn_ff  <= mn_in;
      mx_ff  <= mx_in;
      med_ff <= med_in;
      sum_ff <= sum_in;
   end

   assign ctrl_o = ctrl_ff;
   assign mn     = mn_ff;
   assign mx     = mx_ff;
   assign med    = med_ff;
   assign sum    = sum_ff;

endmodule

// ===== design/wos_mean.sv =====
// Mean unit: four-stage reciprocal multiply (three) or shift-add series (five, nine).
module wos_mean
   #(parameter int SAMPLE_BITS = wos_pkg::SAMPLE_BITS_DEF)
   (
   input  logic                            clock,
   input  logic [1:0]                      win_i,
   input  logic signed [SAMPLE_BITS+3:0]   sum_i,
   output logic [wos_pkg::OUT_BITS-1:0]    mean
   );
   import wos_pkg::*;

   localparam int SUM_W = SAMPLE_BITS + 4;
   localparam int W     = SAMPLE_BITS + 10;
   localparam int PW    = (SUM_W + 31 > 31 + OUT_BITS) ? SUM_W + 31 : 31 + OUT_BITS;
   localparam logic signed [31:0] DIV3_K = 32'(DIV3_MUL / 2);

   function automatic logic is_nine(input logic [1:0] w);
      return !(w == WIN_3 || w == WIN_5);
   endfunction

   logic signed [W-1:0]  xe;
   logic signed [W-1:0]  t_in, t_ff, u_in, u_ff, v_in, v_ff, w_in, w_ff, w_sh;
   logic signed [PW-1:0] prod_in, prod_ff;
   logic [OUT_BITS-1:0]  q3a_ff, q3b_ff, q3c_ff;
   logic [1:0]           win1_ff, win2_ff, win3_ff, win4_ff;

   always_comb begin
      xe      = W'(sum_i);
      t_in    = is_nine(win_i) ? (xe <<< 3) - xe : (xe <<< 1) + xe;
      prod_in = PW'(sum_i) * PW'(DIV3_K);
      u_in    = (is_nine(win1_ff) ? (t_ff >>> 6) : (t_ff >>> 4)) + t_ff;
      v_in    = (is_nine(win2_ff) ? (u_ff >>> 12) : (u_ff >>> 8)) + u_ff;
      w_in    = is_nine(win3_ff) ? (v_ff >>> 24) + v_ff + W'(DIV9_ROUND)
                                 : (v_ff >>> 16) + v_ff + W'(DIV5_ROUND);
      w_sh    = is_nine(win4_ff) ? (w_ff >>> 6) : (w_ff >>> 4);
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      prod_ff <= prod_in;
      win1_ff <= win_i;
      u_ff    <= u_in;
      q3a_ff  <= prod_ff[31 +: OUT_BITS];
      win2_ff <= win1_ff;
      v_ff    <= v_in;
      q3b_ff  <= q3a_ff;
      win3_ff <= win2_ff;
      w_ff    <= w_in;
      q3c_ff  <= q3b_ff;
      win4_ff <= win3_ff;
   end

   assign mean = (win4_ff == WIN_3) ? q3c_ff : w_sh[OUT_BITS-1:0];

endmodule

// ===== design/window_order_statistics.sv =====
// Top level: min, median, max, span and mean over a window of 3, 5 or 9 samples.
//
//   channel   ports                                  transfer when
//   request   start, busy, req_opcode, req_sample_*  start high, busy low
//   result    rsp_valid, rsp_statistic               rsp_valid high (one cycle)
//   config    csr_valid, csr_ready, csr_window_size  csr_valid and csr_ready high
//
// One window per clock; the result strobe follows the request transfer through
// the lane, merge and four mean stages plus the output register.
// busy stays low, so requests are never held off; results cannot be stalled.
// Reset clears the pipeline valids and sets the window to nine samples.
module window_order_statistics
   #(parameter int SAMPLE_BITS = wos_pkg::SAMPLE_BITS_DEF)
   (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_opcode,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_0,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_1,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_2,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_3,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_4,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_5,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_6,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_7,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_8,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_window_size,
   output logic                               rsp_valid,
   output logic signed [wos_pkg::OUT_BITS-1:0] rsp_statistic
   );
   import wos_pkg::*;

   localparam int TAIL    = 4;
   localparam int LATENCY = TAIL + 3;
   localparam int SPAN_W  = SAMPLE_BITS + 1;
   localparam int EXT_W   = (SPAN_W > OUT_BITS) ? SPAN_W : OUT_BITS;

   function automatic logic signed [SAMPLE_BITS-1:0] lo2(
      input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] hi2(
      input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b);
      return (a > b) ? a : b;
   endfunction

   logic                          accept;
   logic [1:0]                    window_size_ff;
   logic signed [SAMPLE_BITS-1:0] smp [9];

   ctrl_type                      ctrl1_in, ctrl1_ff;
   logic signed [SAMPLE_BITS-1:0] s2_ff, s3_ff, s4_ff, m5_lo_in, m5_lo_ff, m5_hi_in, m5_hi_ff;

   logic signed [SAMPLE_BITS-1:0] lane_lo  [3];
   logic signed [SAMPLE_BITS-1:0] lane_mid [3];
   logic signed [SAMPLE_BITS-1:0] lane_hi  [3];
   logic signed [SAMPLE_BITS+1:0] lane_sum [3];

   ctrl_type                      mrg_ctrl;
   logic signed [SAMPLE_BITS-1:0] mrg_mn, mrg_mx, mrg_med;
   logic signed [SAMPLE_BITS+3:0] mrg_sum;

   logic signed [SPAN_W-1:0]      span;
   logic signed [EXT_W-1:0]       os_ext;
   logic [OUT_BITS-1:0]           os_in;
   logic [OUT_BITS-1:0]           os_tail_ff   [TAIL];
   ctrl_type                      ctrl_tail_ff [TAIL];
   logic [OUT_BITS-1:0]           mean;

   logic                          rsp_valid_ff;
   logic [OUT_BITS-1:0]           rsp_statistic_in, rsp_statistic_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WIN_9;
      end else if (csr_valid && csr_ready) begin
         window_size_ff <= csr_window_size;
      end
   end

   assign smp[0] = req_sample_0;
   assign smp[1] = req_sample_1;
   assign smp[2] = req_sample_2;
   assign smp[3] = req_sample_3;
   assign smp[4] = req_sample_4;
   assign smp[5] = req_sample_5;
   assign smp[6] = req_sample_6;
   assign smp[7] = req_sample_7;
   assign smp[8] = req_sample_8;

   // Lane stage; the five-sample median needs the raw pairs, prepared alongside
   always_comb begin
      ctrl1_in = '{valid: accept, opcode: req_opcode, win: window_size_ff};
      m5_lo_in = hi2(lo2(smp[0], smp[1]), lo2(smp[3], smp[4]));
      m5_hi_in = lo2(hi2(smp[0], smp[1]), hi2(smp[3], smp[4]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
      end else begin
         ctrl1_ff <= ctrl1_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff    <= smp[2];
      s3_ff    <= smp[3];
      s4_ff    <= smp[4];
      m5_lo_ff <= m5_lo_in;
      m5_hi_ff <= m5_hi_in;
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      wos_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
         .clock (clock),
         .smp_a (smp[3*g]),
         .smp_b (smp[3*g+1]),
         .smp_c (smp[3*g+2]),
         .lo    (lane_lo[g]),
         .mid   (lane_mid[g]),
         .hi    (lane_hi[g]),
         .sum   (lane_sum[g])
      );
   end

   wos_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctrl_i   (ctrl1_ff),
      .lane_lo  (lane_lo),
      .lane_mid (lane_mid),
      .lane_hi  (lane_hi),
      .lane_sum (lane_sum),
      .s2       (s2_ff),
      .s3       (s3_ff),
      .s4       (s4_ff),
      .m5_lo    (m5_lo_ff),
      .m5_hi    (m5_hi_ff),
      .ctrl_o   (mrg_ctrl),
      .mn       (mrg_mn),
      .mx       (mrg_mx),
      .med      (mrg_med),
      .sum      (mrg_sum)
   );

   // Mean runs TAIL stages, matched by the order-statistic tail below
   wos_mean #(.SAMPLE_BITS(SAMPLE_BITS)) u_mean (
      .clock (clock),
      .win_i (mrg_ctrl.win),
      .sum_i (mrg_sum),
      .mean  (mean)
   );

   always_comb begin
      span = SPAN_W'(mrg_mx) - SPAN_W'(mrg_mn);
      unique case (mrg_ctrl.opcode)
         OP_MIN:    os_ext = EXT_W'(mrg_mn);
         OP_MEDIAN: os_ext = EXT_W'(mrg_med);
         OP_MAX:    os_ext = EXT_W'(mrg_mx);
         OP_SPAN:   os_ext = EXT_W'(span);
         default:   os_ext = '0;
      endcase
      os_in = os_ext[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAIL; i++) begin
            ctrl_tail_ff[i] <= '0;
         end
      end else begin
         ctrl_tail_ff[0] <= mrg_ctrl;
         for (int i = 1; i < TAIL; i++) begin
            ctrl_tail_ff[i] <= ctrl_tail_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      os_tail_ff[0] <= os_in;
      for (int i = 1; i < TAIL; i++) begin
         os_tail_ff[i] <= os_tail_ff[i-1];
      end
   end

   assign rsp_statistic_in = (ctrl_tail_ff[TAIL-1].opcode == OP_MEAN) ? mean
                                                                       : os_tail_ff[TAIL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl_tail_ff[TAIL-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_statistic_ff <= rsp_statistic_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_statistic = rsp_statistic_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("request transfer without result strobe at fixed latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without matching request transfer");

   a_order: assert property (@(posedge clock) disable iff (reset)
      mrg_ctrl.valid |-> (mrg_mn <= mrg_med) && (mrg_med <= mrg_mx))
      else $error("merge stage order statistics out of order");

endmodule
